// File: hw/rtl/qclt_pkg.sv
`default_nettype none

package qclt_pkg;

   localparam int MaxTokensDefault = 32;

   localparam logic [7:0]  BYTE_NL    = 8'd10;
   localparam logic [7:0]  BYTE_SPACE = 8'd32;
   localparam logic [7:0]  BYTE_QUOTE = 8'd34;
   localparam logic [63:0] HASH_SEED  = 64'h1505;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ODD_QUOTE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'b001,
      MODE_SPACE   = 3'b010,
      MODE_PENDING = 3'b100
   } scan_mode_type;

   typedef struct packed {
      logic          in_quotes;
      scan_mode_type scan_mode;
      logic          at_line_start;
      logic          first_token_open;
      logic          quote_parity;
      logic          token_overflow;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      in_quotes:        1'b0,
      scan_mode:        MODE_NORMAL,
      at_line_start:    1'b1,
      first_token_open: 1'b1,
      quote_parity:     1'b0,
      token_overflow:   1'b0
   };

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        token_start;
      logic [4:0]  token_number;
      logic        line_done;
      logic [1:0]  line_status;
      logic [5:0]  token_count;
      logic [63:0] command_hash;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hw/rtl/qclt_if.sv
`default_nettype none

interface qclt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;

   modport source (output valid, output line_byte, input ready);
   modport sink   (input valid, input line_byte, output ready);
endinterface

interface qclt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        token_start;
   logic [4:0]  token_number;
   logic        line_done;
   logic [1:0]  line_status;
   logic [5:0]  token_count;
   logic [63:0] command_hash;

   modport source (output valid, output out_byte, output token_start, output token_number,
                   output line_done, output line_status, output token_count,
                   output command_hash, input ready);
   modport sink   (input valid, input out_byte, input token_start, input token_number,
                   input line_done, input line_status, input token_count,
                   input command_hash, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qclt_step.sv
`default_nettype none

module qclt_step
   import qclt_pkg::*;
#(
   parameter int MAX_TOKENS = MaxTokensDefault,
   localparam int TokW = $clog2(MAX_TOKENS + 1)
) (
   input  wire logic [7:0]      line_byte,
   input  wire scan_state_type  state,
   input  wire logic [TokW-1:0] tokens_seen,
   input  wire logic [63:0]     running_hash,
   output scan_state_type       state_in,
   output logic [TokW-1:0]      tokens_seen_in,
   output logic [63:0]          running_hash_in,
   output rsp_word_type         rsp_word
);

   logic [TokW-1:0]   tokens_m1;
   logic [TokW+5:0]   tokens_ext;
   logic [TokW+5:0]   tokens_m1_ext;
   logic [TokW-1:0]   tokens_next;
   logic [7:0]        ob;
   logic              start;
   logic              is_quote;
   logic              is_space;

   assign is_quote = (line_byte == BYTE_QUOTE);
   assign is_space = (line_byte == BYTE_SPACE);

   assign tokens_m1     = tokens_seen - TokW'(1);
   assign tokens_ext    = {6'd0, tokens_seen};
   assign tokens_m1_ext = {6'd0, tokens_m1};

   always_comb begin
      state_in        = state;
      tokens_next     = tokens_seen;
      running_hash_in = running_hash;
      ob              = 8'd0;
      start           = 1'b0;
      rsp_word        = '0;

      if (line_byte == BYTE_NL) begin
         rsp_word.token_start  = state.at_line_start;
         rsp_word.token_number = tokens_m1_ext[4:0];
         rsp_word.line_done    = 1'b1;
         if (state.quote_parity) begin
            rsp_word.line_status = STATUS_ODD_QUOTE;
         end else if (state.token_overflow) begin
            rsp_word.line_status = STATUS_OVERFLOW;
         end else begin
            rsp_word.line_status = STATUS_OK;
         end
         rsp_word.token_count  = tokens_ext[5:0];
         rsp_word.command_hash = running_hash;
         // newline rearms the scanner for the next line
         state_in        = SCAN_STATE_RESET;
         tokens_next     = TokW'(1);
         running_hash_in = HASH_SEED;
      end else begin
         state_in.quote_parity = state.quote_parity ^ is_quote;

         if (!state.token_overflow) begin
            if (state.at_line_start) begin
               start                  = 1'b1;
               state_in.at_line_start = 1'b0;
            end
            unique case (state.scan_mode)
               MODE_SPACE: begin
                  if (is_space) begin
                     ob = 8'd0;
                  end else if (is_quote) begin
                     ob                 = 8'd0;
                     state_in.in_quotes = ~state.in_quotes;
                     state_in.scan_mode = MODE_PENDING;
                  end else begin
                     ob                 = line_byte;
                     start              = 1'b1;
                     tokens_next        = tokens_seen + TokW'(1);
                     state_in.scan_mode = MODE_NORMAL;
                  end
               end
               MODE_PENDING: begin
                  start       = 1'b1;
                  tokens_next = tokens_seen + TokW'(1);
                  if (is_quote) begin
                     ob                 = 8'd0;
                     state_in.in_quotes = ~state.in_quotes;
                  end else begin
                     ob = line_byte;
                  end
                  state_in.scan_mode = MODE_NORMAL;
               end
               default: begin
                  if (is_space && !state.in_quotes) begin
                     ob                 = 8'd0;
                     state_in.scan_mode = MODE_SPACE;
                  end else if (is_quote) begin
                     ob                 = 8'd0;
                     state_in.in_quotes = ~state.in_quotes;
                  end else begin
                     ob = line_byte;
                  end
               end
            endcase

            // hash token 0 up to its first zero byte
            if (state.first_token_open) begin
               if (ob == 8'd0) begin
                  state_in.first_token_open = 1'b0;
               end else begin
                  running_hash_in = (running_hash << 5) + running_hash + {56'd0, ob};
               end
            end

            if (tokens_next >= TokW'(MAX_TOKENS)) begin
               state_in.token_overflow = 1'b1;
            end
         end

         rsp_word.out_byte     = ob;
         rsp_word.token_start  = start;
         rsp_word.token_number = 5'((tokens_next - TokW'(1)) & TokW'({TokW{1'b1}}));
      end
      tokens_seen_in = tokens_next;
   end

endmodule

`default_nettype wire

// File: hw/rtl/quoted_command_line_tokenizer_unit.sv
// Quoted command-line tokenizer.
// Bytes of a command line arrive one word at a time on req_chan; every accepted
// byte gives exactly one word on rsp_chan: the rewritten byte (spaces outside
// quotes and quote marks become 0), a token-start flag and the token number.
// The newline byte (10) closes the line: its word carries line_done with the
// status (ok, odd quote count, token limit reached), the token count and the
// 64-bit djb2 hash of the first token, then the scanner rearms for a new line.
// Per-byte words are tentative until that status arrives.
// The result word of each accepted byte is registered in the output register.
// Throughput: one byte per cycle while rsp_chan takes each word; the scan state
// and the hash shift-add update sit in one combinational step between the state
// registers and the output register.
// When rsp_chan stalls, the output register holds its word and req_chan.ready
// drops until that word is taken; a word taken frees the slot in the same cycle.
// Reset (synchronous, active high) empties the output register and puts the
// scanner at the start of a line with the hash at its seed.
`default_nettype none

module quoted_command_line_tokenizer_unit
   import qclt_pkg::*;
#(
   parameter int MAX_TOKENS = MaxTokensDefault,
   localparam int TokW = $clog2(MAX_TOKENS + 1)
) (
   input wire logic   clock,
   input wire logic   reset,
   qclt_req_if.sink   req_chan,
   qclt_rsp_if.source rsp_chan
);

   scan_state_type  state_ff, state_in;
   logic [TokW-1:0] tokens_seen_ff, tokens_seen_in;
   logic [63:0]     running_hash_ff, running_hash_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;
   logic            rsp_valid_ff;
   logic            req_fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   qclt_step #(
      .MAX_TOKENS(MAX_TOKENS)
   ) u_step (
      .line_byte      (req_chan.line_byte),
      .state          (state_ff),
      .tokens_seen    (tokens_seen_ff),
      .running_hash   (running_hash_ff),
      .state_in       (state_in),
      .tokens_seen_in (tokens_seen_in),
      .running_hash_in(running_hash_in),
      .rsp_word       (rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SCAN_STATE_RESET;
         tokens_seen_ff  <= TokW'(1);
         running_hash_ff <= HASH_SEED;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff        <= state_in;
            tokens_seen_ff  <= tokens_seen_in;
            running_hash_ff <= running_hash_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_byte     = rsp_word_ff.out_byte;
   assign rsp_chan.token_start  = rsp_word_ff.token_start;
   assign rsp_chan.token_number = rsp_word_ff.token_number;
   assign rsp_chan.line_done    = rsp_word_ff.line_done;
   assign rsp_chan.line_status  = rsp_word_ff.line_status;
   assign rsp_chan.token_count  = rsp_word_ff.token_count;
   assign rsp_chan.command_hash = rsp_word_ff.command_hash;

   a_newline_rearms : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.line_byte == BYTE_NL |=>
         tokens_seen_ff == TokW'(1) && running_hash_ff == HASH_SEED && state_ff.at_line_start)
      else $error("scanner not rearmed after newline");

   a_tokens_in_range : assert property (@(posedge clock) disable iff (reset)
      tokens_seen_ff != '0 && tokens_seen_ff <= TokW'(MAX_TOKENS))
      else $error("token counter out of range");

   a_overflow_at_limit : assert property (@(posedge clock) disable iff (reset)
      state_ff.token_overflow |-> tokens_seen_ff == TokW'(MAX_TOKENS))
      else $error("overflow flag without token limit");

   a_status_only_on_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.line_done |->
         rsp_word_ff.line_status == STATUS_OK && rsp_word_ff.token_count == 6'd0 &&
         rsp_word_ff.command_hash == 64'd0)
      else $error("status fields set on a non-newline word");

   a_accept_fills_output : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted byte produced no result word");

endmodule

`default_nettype wire
